// File: rtl/third_order_complementary_filter_macros.svh
// ============================================================================
// third_order_complementary_filter_macros.svh
// Assertion macros for the complementary filter. They compile to nothing
// when SYNTHESIS is defined. They expect clk and rst_n in the calling scope.
// ============================================================================
`ifndef THIRD_ORDER_COMPLEMENTARY_FILTER_MACROS_SVH
`define THIRD_ORDER_COMPLEMENTARY_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define TOCF_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("tocf: same-cycle check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define TOCF_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("tocf: next-cycle check failed");

`else

`define TOCF_ASSERT_IMP(lbl, ant, cons)
`define TOCF_ASSERT_NXT(lbl, ant, cons)

`endif

`endif

// File: rtl/tocf_pkg.sv
// ============================================================================
// tocf_pkg
// Shared types, constants and the control program of the complementary
// filter sequencer.
// ============================================================================
package tocf_pkg;

  // Q16.16 signed value.
  typedef logic signed [31:0] q_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_GAIN_ACC  = 2'd0,
    CFG_GAIN_VEL  = 2'd1,
    CFG_GAIN_POS  = 2'd2,
    CFG_TIME_STEP = 2'd3
  } cfg_idx_t;

  localparam int unsigned GainW = 31;
  localparam int unsigned TstepW = 17;
  localparam int unsigned CfgDataW = 31;

  localparam logic [GainW-1:0]  GainAccRst = 31'd511;
  localparam logic [GainW-1:0]  GainVelRst = 31'd1369;
  localparam logic [GainW-1:0]  GainPosRst = 31'd1467;
  localparam logic [TstepW-1:0] TstepRst   = 17'd655;

  // Blend weights 0.8 and 0.2 in Q0.16.
  localparam logic signed [31:0] BlendPosW = 32'sd52429;
  localparam logic signed [31:0] BlendVelW = 32'sd13107;

  // One input item and one result item.
  typedef struct packed {
    q_t   meas_pos;
    q_t   meas_vel;
    q_t   meas_acc;
    logic use_pos;
    logic use_vel;
    logic use_acc;
  } in_item_t;

  typedef struct packed {
    q_t   est_pos;
    q_t   est_vel;
    q_t   est_acc;
    logic updated;
  } est_t;

  // Multiplier operand selects.
  typedef enum logic [2:0] {
    A_EP      = 3'd0,
    A_EV      = 3'd1,
    A_ERR     = 3'd2,
    A_ACC_EST = 3'd3,
    A_V2D     = 3'd4
  } a_sel_t;

  typedef enum logic [2:0] {
    B_BLEND_POS = 3'd0,
    B_BLEND_VEL = 3'd1,
    B_GAIN_ACC  = 3'd2,
    B_GAIN_VEL  = 3'd3,
    B_GAIN_POS  = 3'd4,
    B_TIME_STEP = 3'd5
  } b_sel_t;

  // Adder operations and their destination registers.
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_DIFF_P   = 4'd1,
    OP_DIFF_V   = 4'd2,
    OP_ERR_SEL  = 4'd3,
    OP_ACC_CORR = 4'd4,
    OP_VEL_CORR = 4'd5,
    OP_POS_CORR = 4'd6,
    OP_ACC_EST  = 4'd7,
    OP_D_STEP   = 4'd8,
    OP_VEL_D    = 4'd9,
    OP_POS_INT  = 4'd10,
    OP_COMMIT   = 4'd11
  } op_t;

  typedef enum logic [1:0] {
    FLOW_NEXT        = 2'd0,
    FLOW_END_NO_MEAS = 2'd1,
    FLOW_END_NO_ACC  = 2'd2,
    FLOW_END         = 2'd3
  } flow_t;

  typedef logic [3:0] step_t;

  // One control word of the program.
  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic   mul_en;
    logic   mul_acc;
    logic   rnd17;
    op_t    op;
    flow_t  flow;
  } ctrl_t;

  // Item flags the program branches on.
  typedef struct packed {
    logic no_meas;
    logic no_acc;
  } stat_t;

  localparam ctrl_t CtrlNop = '{
    a_sel:   A_EP,
    b_sel:   B_BLEND_POS,
    mul_en:  1'b0,
    mul_acc: 1'b0,
    rnd17:   1'b0,
    op:      OP_NONE,
    flow:    FLOW_NEXT
  };

  // Control program. The product register written in one step is read
  // through the rounding shifter in the following step.
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t c;
    c = CtrlNop;
    case (step)
      4'd0: begin
        c.op = OP_DIFF_P;
        c.flow = FLOW_END_NO_MEAS;
      end
      4'd1: begin
        c.op = OP_DIFF_V;
      end
      4'd2: begin
        c.a_sel = A_EP;
        c.b_sel = B_BLEND_POS;
        c.mul_en = 1'b1;
      end
      4'd3: begin
        c.a_sel = A_EV;
        c.b_sel = B_BLEND_VEL;
        c.mul_en = 1'b1;
        c.mul_acc = 1'b1;
      end
      4'd4: begin
        c.op = OP_ERR_SEL;
      end
      4'd5: begin
        c.a_sel = A_ERR;
        c.b_sel = B_GAIN_ACC;
        c.mul_en = 1'b1;
      end
      4'd6: begin
        c.op = OP_ACC_CORR;
        c.a_sel = A_ERR;
        c.b_sel = B_GAIN_VEL;
        c.mul_en = 1'b1;
      end
      4'd7: begin
        c.op = OP_VEL_CORR;
        c.a_sel = A_ERR;
        c.b_sel = B_GAIN_POS;
        c.mul_en = 1'b1;
      end
      4'd8: begin
        c.op = OP_POS_CORR;
        c.flow = FLOW_END_NO_ACC;
      end
      4'd9: begin
        c.op = OP_ACC_EST;
      end
      4'd10: begin
        c.a_sel = A_ACC_EST;
        c.b_sel = B_TIME_STEP;
        c.mul_en = 1'b1;
      end
      4'd11: begin
        c.op = OP_D_STEP;
      end
      4'd12: begin
        c.op = OP_VEL_D;
        c.a_sel = A_V2D;
        c.b_sel = B_TIME_STEP;
        c.mul_en = 1'b1;
      end
      4'd13: begin
        c.op = OP_POS_INT;
        c.rnd17 = 1'b1;
      end
      4'd14: begin
        c.op = OP_COMMIT;
        c.flow = FLOW_END;
      end
      default: begin
        c.flow = FLOW_END;
      end
    endcase
    return c;
  endfunction

endpackage

// File: rtl/tocf_in_if.sv
// ============================================================================
// tocf_in_if
// Measurement channel: valid/ready handshake with one item per beat.
// ============================================================================
interface tocf_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] meas_pos;
  logic signed [31:0] meas_vel;
  logic signed [31:0] meas_acc;
  logic              use_pos;
  logic              use_vel;
  logic              use_acc;

  modport source (
    output valid, meas_pos, meas_vel, meas_acc, use_pos, use_vel, use_acc,
    input  ready
  );

  modport sink (
    input  valid, meas_pos, meas_vel, meas_acc, use_pos, use_vel, use_acc,
    output ready
  );
endinterface

// File: rtl/tocf_out_if.sv
// ============================================================================
// tocf_out_if
// Estimate channel: valid/ready handshake with one result per beat.
// ============================================================================
interface tocf_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] est_pos;
  logic signed [31:0] est_vel;
  logic signed [31:0] est_acc;
  logic              updated;

  modport source (
    output valid, est_pos, est_vel, est_acc, updated,
    input  ready
  );

  modport sink (
    input  valid, est_pos, est_vel, est_acc, updated,
    output ready
  );
endinterface

// File: rtl/tocf_seq.sv
// ============================================================================
// tocf_seq
// Step counter, program table and control state of the filter. Issues one
// control word per cycle while an item is being processed.
// ============================================================================
module tocf_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             out_free,
  input  tocf_pkg::stat_t  stat,
  output tocf_pkg::ctrl_t  ctrl,
  output logic             in_ready,
  output logic             load_out
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } seq_state_t;

  seq_state_t       state_r, state_nxt;
  tocf_pkg::step_t  step_r, step_nxt;
  tocf_pkg::ctrl_t  word;
  logic             finish;

  // Program fetch; outside a run the datapath sees a no-op word.
  always_comb begin
    word = tocf_pkg::ucode(step_r);
    ctrl = (state_r == ST_RUN) ? word : tocf_pkg::CtrlNop;
  end

  // Conditional end of the program.
  always_comb begin
    case (word.flow)
      tocf_pkg::FLOW_NEXT:        finish = 1'b0;
      tocf_pkg::FLOW_END_NO_MEAS: finish = stat.no_meas;
      tocf_pkg::FLOW_END_NO_ACC:  finish = stat.no_acc;
      tocf_pkg::FLOW_END:         finish = 1'b1;
      default:                    finish = 1'b1;
    endcase
  end

  // Next state and step.
  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          step_nxt = '0;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ST_DONE: begin
        load_out = out_free;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

// File: rtl/tocf_dp.sv
// ============================================================================
// tocf_dp
// Datapath of the filter: configuration registers, filter state, one shared
// multiplier with a product register and rounding shifter, and one
// saturating adder, all steered by the control word.
// ============================================================================
module tocf_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [tocf_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                            start,
  input  tocf_pkg::in_item_t              item,
  input  tocf_pkg::ctrl_t                 ctrl,
  output tocf_pkg::stat_t                 stat,
  output tocf_pkg::est_t                  est
);

  // Sign-extend a Q16.16 value to the adder width.
  function automatic logic signed [48:0] ext49(input logic signed [31:0] v);
    return {{17{v[31]}}, v};
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
    logic signed [31:0] r;
    if (x > 49'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -49'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  logic [tocf_pkg::GainW-1:0]  gain_acc_r, gain_vel_r, gain_pos_r;
  logic [tocf_pkg::TstepW-1:0] tstep_r;

  tocf_pkg::in_item_t item_r;

  tocf_pkg::q_t ep_r, ev_r, err_r, d_r;
  tocf_pkg::q_t pos_est_r, vel_est_r, acc_est_r;
  tocf_pkg::q_t pos_corr_r, vel_corr_r, acc_corr_r, pos_int_r;
  logic         upd_r;

  logic signed [63:0] prod_r, prod_nxt;
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] mul_full;
  logic signed [63:0] rnd_sum, rnd_shift;
  logic signed [48:0] rnd;
  logic signed [48:0] add_x, add_y, add_sum;
  tocf_pkg::q_t       add_sat;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_acc_r <= tocf_pkg::GainAccRst;
      gain_vel_r <= tocf_pkg::GainVelRst;
      gain_pos_r <= tocf_pkg::GainPosRst;
      tstep_r <= tocf_pkg::TstepRst;
    end else if (cfg_we) begin
      case (tocf_pkg::cfg_idx_t'(cfg_index))
        tocf_pkg::CFG_GAIN_ACC:  gain_acc_r <= cfg_data;
        tocf_pkg::CFG_GAIN_VEL:  gain_vel_r <= cfg_data;
        tocf_pkg::CFG_GAIN_POS:  gain_pos_r <= cfg_data;
        tocf_pkg::CFG_TIME_STEP: tstep_r <= cfg_data[tocf_pkg::TstepW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (start) begin
      item_r <= item;
    end
  end

  assign stat.no_meas = !(item_r.use_pos || item_r.use_vel);
  assign stat.no_acc = !item_r.use_acc;

  // Multiplier operands.
  always_comb begin
    case (ctrl.a_sel)
      tocf_pkg::A_EP:      mul_a = {{2{ep_r[31]}}, ep_r};
      tocf_pkg::A_EV:      mul_a = {{2{ev_r[31]}}, ev_r};
      tocf_pkg::A_ERR:     mul_a = {{2{err_r[31]}}, err_r};
      tocf_pkg::A_ACC_EST: mul_a = {{2{acc_est_r[31]}}, acc_est_r};
      tocf_pkg::A_V2D:     mul_a = {vel_est_r[31], vel_est_r, 1'b0} +
                                   {{2{d_r[31]}}, d_r};
      default:             mul_a = '0;
    endcase
    case (ctrl.b_sel)
      tocf_pkg::B_BLEND_POS: mul_b = tocf_pkg::BlendPosW;
      tocf_pkg::B_BLEND_VEL: mul_b = tocf_pkg::BlendVelW;
      tocf_pkg::B_GAIN_ACC:  mul_b = {1'b0, gain_acc_r};
      tocf_pkg::B_GAIN_VEL:  mul_b = {1'b0, gain_vel_r};
      tocf_pkg::B_GAIN_POS:  mul_b = {1'b0, gain_pos_r};
      tocf_pkg::B_TIME_STEP: mul_b = {15'd0, tstep_r};
      default:               mul_b = '0;
    endcase
  end

  // Shared multiplier; all products stay well inside 63 bits.
  assign mul_full = mul_a * mul_b;
  assign prod_nxt = ctrl.mul_acc ? prod_r + mul_full[63:0] : mul_full[63:0];

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Round half up by 16 or 17 bits.
  always_comb begin
    rnd_sum = prod_r + (ctrl.rnd17 ? 64'sd65536 : 64'sd32768);
    rnd_shift = ctrl.rnd17 ? (rnd_sum >>> 17) : (rnd_sum >>> 16);
    rnd = rnd_shift[48:0];
  end

  // Saturating adder operands per operation.
  always_comb begin
    add_x = '0;
    add_y = '0;
    case (ctrl.op)
      tocf_pkg::OP_DIFF_P: begin
        add_x = ext49(item_r.meas_pos);
        add_y = -ext49(pos_est_r);
      end
      tocf_pkg::OP_DIFF_V: begin
        add_x = ext49(item_r.meas_vel);
        add_y = -ext49(vel_est_r);
      end
      tocf_pkg::OP_ERR_SEL,
      tocf_pkg::OP_D_STEP: begin
        add_y = rnd;
      end
      tocf_pkg::OP_ACC_CORR: begin
        add_x = ext49(acc_corr_r);
        add_y = rnd;
      end
      tocf_pkg::OP_VEL_CORR: begin
        add_x = ext49(vel_corr_r);
        add_y = rnd;
      end
      tocf_pkg::OP_POS_CORR: begin
        add_x = ext49(pos_corr_r);
        add_y = rnd;
      end
      tocf_pkg::OP_ACC_EST: begin
        add_x = ext49(item_r.meas_acc);
        add_y = ext49(acc_corr_r);
      end
      tocf_pkg::OP_VEL_D: begin
        add_x = ext49(vel_corr_r);
        add_y = ext49(d_r);
      end
      tocf_pkg::OP_POS_INT: begin
        add_x = ext49(pos_int_r);
        add_y = rnd;
      end
      tocf_pkg::OP_COMMIT: begin
        add_x = ext49(pos_int_r);
        add_y = ext49(pos_corr_r);
      end
      default: begin
      end
    endcase
  end

  assign add_sum = add_x + add_y;
  assign add_sat = sat32(add_sum);

  // Work registers of the current item.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      tocf_pkg::OP_DIFF_P: ep_r <= add_sat;
      tocf_pkg::OP_DIFF_V: ev_r <= add_sat;
      tocf_pkg::OP_ERR_SEL: begin
        if (item_r.use_pos && !item_r.use_vel) begin
          err_r <= ep_r;
        end else if (!item_r.use_pos) begin
          err_r <= ev_r;
        end else begin
          err_r <= add_sat;
        end
      end
      tocf_pkg::OP_D_STEP: d_r <= add_sat;
      default: begin
      end
    endcase
  end

  // Filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_est_r <= '0;
      vel_est_r <= '0;
      acc_est_r <= '0;
      pos_corr_r <= '0;
      vel_corr_r <= '0;
      acc_corr_r <= '0;
      pos_int_r <= '0;
      upd_r <= 1'b0;
    end else begin
      if (start) begin
        upd_r <= 1'b0;
      end
      case (ctrl.op)
        tocf_pkg::OP_ACC_CORR: acc_corr_r <= add_sat;
        tocf_pkg::OP_VEL_CORR,
        tocf_pkg::OP_VEL_D:    vel_corr_r <= add_sat;
        tocf_pkg::OP_POS_CORR: pos_corr_r <= add_sat;
        tocf_pkg::OP_ACC_EST:  acc_est_r <= add_sat;
        tocf_pkg::OP_POS_INT:  pos_int_r <= add_sat;
        tocf_pkg::OP_COMMIT: begin
          pos_est_r <= add_sat;
          vel_est_r <= vel_corr_r;
          upd_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign est.est_pos = pos_est_r;
  assign est.est_vel = vel_est_r;
  assign est.est_acc = acc_est_r;
  assign est.updated = upd_r;

endmodule

// File: rtl/third_order_complementary_filter.sv
// ============================================================================
// third_order_complementary_filter
// One-axis third-order complementary filter in Q16.16 fixed point.
// ============================================================================
// Usage:
// - in_bus carries one measurement beat: position, velocity, acceleration
//   and three use flags. out_bus returns one estimate beat per input beat.
// - cfg_we/cfg_index/cfg_data write the three correction gains and the
//   time step; write them only while the filter is idle.
// - Processing runs a 15-step program on one shared multiplier and one
//   saturating adder, one step per cycle. An item that uses acceleration
//   and position or velocity runs the whole program; the program ends
//   after step 8 when acceleration is unused and after step 0 when no
//   position or velocity is used. The filter takes one item at a time, so
//   a new beat is accepted only after the previous item is done.
// - The result sits in an output register, so the next beat is accepted
//   while the previous result still waits to be taken.
// - If the receiver stalls, the filter holds in its final step until the
//   output register is free; in_bus.ready stays low meanwhile.
// - Reset clears all estimates, corrections and the position integrator and
//   restores the default gains and time step; no output beat is pending after reset.
// ============================================================================
`include "third_order_complementary_filter_macros.svh"

module third_order_complementary_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [tocf_pkg::CfgDataW-1:0] cfg_data,
  tocf_in_if.sink                       in_bus,
  tocf_out_if.source                    out_bus
);

  tocf_pkg::in_item_t item;
  tocf_pkg::ctrl_t    ctrl;
  tocf_pkg::stat_t    stat;
  tocf_pkg::est_t     est;
  tocf_pkg::est_t     out_r;
  logic               out_valid_r;
  logic               start;
  logic               in_ready;
  logic               load_out;
  logic               out_free;

  // Input beat.
  assign item.meas_pos = in_bus.meas_pos;
  assign item.meas_vel = in_bus.meas_vel;
  assign item.meas_acc = in_bus.meas_acc;
  assign item.use_pos = in_bus.use_pos;
  assign item.use_vel = in_bus.use_vel;
  assign item.use_acc = in_bus.use_acc;
  assign in_bus.ready = in_ready;
  assign start = in_bus.valid && in_ready;

  assign out_free = !out_valid_r || out_bus.ready;

  tocf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_ready (in_ready),
    .load_out (load_out)
  );

  tocf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .item      (item),
    .ctrl      (ctrl),
    .stat      (stat),
    .est       (est)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= est;
    end
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.est_pos = out_r.est_pos;
  assign out_bus.est_vel = out_r.est_vel;
  assign out_bus.est_acc = out_r.est_acc;
  assign out_bus.updated = out_r.updated;

  // An accepted beat starts a run, so the input closes on the next cycle.
  `TOCF_ASSERT_NXT(a_busy_after_accept, start, !in_bus.ready)
  // The estimates are only committed on items that use acceleration.
  `TOCF_ASSERT_IMP(a_commit_needs_acc, ctrl.op == tocf_pkg::OP_COMMIT, !stat.no_acc && !stat.no_meas)
  // A result is written out only at the end of a run, never while idle.
  `TOCF_ASSERT_IMP(a_load_not_idle, load_out, !in_bus.ready)

endmodule
